// ===== rtl/crtl_pkg.sv =====
// ============================================================================
// crtl_pkg
// Shared constants, beat types and register indexes for the colour ramp
// texel lookup block.
// ============================================================================
package crtl_pkg;

    // Size of the colour stop table and of the texel index.
    localparam int MAX_STOPS     = 16;
    localparam int STOP_BITS     = (MAX_STOPS > 2) ? $clog2(MAX_STOPS) : 1;
    localparam int INDEX_BITS    = 12;

    // Fixed field and register widths.
    localparam int CH_BITS       = 8;
    localparam int STOP_ID_BITS  = 4;
    localparam int COUNT_BITS    = 5;
    localparam int STEP_BITS     = 8;
    localparam int CFG_DATA_BITS = 8;

    // Saturated stop count, wide enough to hold MAX_STOPS itself.
    localparam int N_BITS        = (COUNT_BITS > STOP_BITS + 1) ? COUNT_BITS : STOP_BITS + 1;
    // Width used to compare a texel index against the gradient span.
    localparam int CMP_BITS      = (N_BITS + STEP_BITS > INDEX_BITS) ?
                                   N_BITS + STEP_BITS : INDEX_BITS;
    // Partial remainder of the segment division (index / steps).
    localparam int REM_BITS      = STOP_BITS + STEP_BITS;
    // Weighted channel sum, at most 255 * steps.
    localparam int PROD_BITS     = CH_BITS + STEP_BITS;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_STOP_COUNT = 1'b0,
        CFG_STEPS      = 1'b1
    } cfg_reg_t;

    // Input beat.
    typedef struct packed {
        logic                    operation;
        logic [STOP_ID_BITS-1:0] stop_index;
        logic [CH_BITS-1:0]      stop_red;
        logic [CH_BITS-1:0]      stop_green;
        logic [CH_BITS-1:0]      stop_blue;
        logic [INDEX_BITS-1:0]   texel_index;
    } item_t;

    // Result beat.
    typedef struct packed {
        logic [CH_BITS-1:0] texel_red;
        logic [CH_BITS-1:0] texel_green;
        logic [CH_BITS-1:0] texel_blue;
        logic               last_texel;
        logic               index_error;
    } result_t;

    // One entry of the stop table.
    typedef struct packed {
        logic [CH_BITS-1:0] red;
        logic [CH_BITS-1:0] green;
        logic [CH_BITS-1:0] blue;
    } stop_t;

    // Per-item control that follows an item down the pipeline.
    typedef struct packed {
        logic lookup;
        logic last;
        logic error;
    } flags_t;

    // Stop write carried to the table stage so loads and lookups stay in order.
    typedef struct packed {
        logic                 en;
        logic [STOP_BITS-1:0] addr;
        stop_t                colour;
    } load_t;

endpackage

// ===== rtl/crtl_stop_ram.sv =====
// ============================================================================
// crtl_stop_ram
// Colour stop table: one write port and two read ports with registered
// read data.
// ============================================================================
module crtl_stop_ram (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [crtl_pkg::STOP_BITS-1:0] wr_addr,
    input  crtl_pkg::stop_t                wr_data,
    input  logic [crtl_pkg::STOP_BITS-1:0] rd_addr_a,
    input  logic [crtl_pkg::STOP_BITS-1:0] rd_addr_b,
    output crtl_pkg::stop_t                rd_data_a,
    output crtl_pkg::stop_t                rd_data_b
);
    import crtl_pkg::*;

    stop_t mem [MAX_STOPS];
    stop_t rd_a_reg;
    stop_t rd_b_reg;

    // Write and both reads happen at the clock edge.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ===== rtl/crtl_quot.sv =====
// ============================================================================
// crtl_quot
// Pipelined restoring divider that splits a texel index into a segment
// number (quotient) and a step within the segment (remainder). One quotient
// bit per stage; load beats ride along unchanged.
// ============================================================================
module crtl_quot (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  crtl_pkg::flags_t               in_flags,
    input  crtl_pkg::load_t                in_load,
    input  logic [crtl_pkg::REM_BITS-1:0]  dividend,
    input  logic [crtl_pkg::STEP_BITS-1:0] divisor,
    output logic                           out_valid,
    output crtl_pkg::flags_t               out_flags,
    output crtl_pkg::load_t                out_load,
    output logic [crtl_pkg::STOP_BITS-1:0] quotient,
    output logic [crtl_pkg::REM_BITS-1:0]  remainder
);
    import crtl_pkg::*;

    logic                 valid_reg [STOP_BITS];
    flags_t               flags_reg [STOP_BITS];
    load_t                load_reg  [STOP_BITS];
    logic [REM_BITS-1:0]  rem_reg   [STOP_BITS];
    logic [STOP_BITS-1:0] quo_reg   [STOP_BITS];

    for (genvar j = 0; j < STOP_BITS; j++)
    begin : g_step
        localparam int SHIFT = STOP_BITS - 1 - j;

        logic                 prev_valid;
        flags_t               prev_flags;
        load_t                prev_load;
        logic [REM_BITS-1:0]  prev_rem;
        logic [STOP_BITS-1:0] prev_quo;
        logic [REM_BITS-1:0]  shifted;
        logic                 take;
        logic [REM_BITS-1:0]  rem_next;
        logic [STOP_BITS-1:0] quo_next;

        // The first stage takes the incoming beat, the others the stage before.
        if (j == 0)
        begin : g_first
            assign prev_valid = in_valid;
            assign prev_flags = in_flags;
            assign prev_load  = in_load;
            assign prev_rem   = dividend;
            assign prev_quo   = '0;
        end
        else
        begin : g_chain
            assign prev_valid = valid_reg[j-1];
            assign prev_flags = flags_reg[j-1];
            assign prev_load  = load_reg[j-1];
            assign prev_rem   = rem_reg[j-1];
            assign prev_quo   = quo_reg[j-1];
        end

        // Trial subtraction of the divisor at this quotient bit.
        assign shifted = REM_BITS'(divisor) << SHIFT;
        assign take    = (prev_rem >= shifted);

        always_comb
        begin
            rem_next = prev_rem;
            quo_next = prev_quo;
            if (take)
            begin
                rem_next        = prev_rem - shifted;
                quo_next[SHIFT] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else
            begin
                valid_reg[j] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            flags_reg[j] <= prev_flags;
            load_reg[j]  <= prev_load;
            rem_reg[j]   <= rem_next;
            quo_reg[j]   <= quo_next;
        end
    end

    assign out_valid = valid_reg[STOP_BITS-1];
    assign out_flags = flags_reg[STOP_BITS-1];
    assign out_load  = load_reg[STOP_BITS-1];
    assign quotient  = quo_reg[STOP_BITS-1];
    assign remainder = rem_reg[STOP_BITS-1];

`ifndef NO_ASSERTIONS
    // Each output beat is an input beat that has passed one stage per quotient bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, STOP_BITS))
    else $error("crtl_quot: output beat without matching input beat");

    // An in-range interior lookup must leave a step below the segment length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_flags.lookup && !out_flags.error && !out_flags.last)
        |-> (remainder < REM_BITS'(divisor)))
    else $error("crtl_quot: step within segment not below steps per segment");
`endif

endmodule

// ===== rtl/crtl_blend.sv =====
// ============================================================================
// crtl_blend
// Blends two neighbouring stops: c1*(S-k) + c2*k per channel, then divides
// by S in a pipelined restoring divider, one result bit per stage, with the
// three channels side by side.
// ============================================================================
module crtl_blend (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  crtl_pkg::flags_t               in_flags,
    input  logic [crtl_pkg::STEP_BITS-1:0] step_k,
    input  logic [crtl_pkg::STEP_BITS-1:0] divisor,
    input  crtl_pkg::stop_t                stop_lo,
    input  crtl_pkg::stop_t                stop_hi,
    output logic                           out_valid,
    output crtl_pkg::flags_t               out_flags,
    output crtl_pkg::stop_t                colour
);
    import crtl_pkg::*;

    localparam int NUM_CH = 3;

    logic [CH_BITS-1:0]   a_ch [NUM_CH];
    logic [CH_BITS-1:0]   b_ch [NUM_CH];
    logic [STEP_BITS-1:0] rest;

    // Product stage.
    logic                 prod_valid_reg;
    flags_t               prod_flags_reg;
    logic [PROD_BITS-1:0] prod_a_reg [NUM_CH];
    logic [PROD_BITS-1:0] prod_b_reg [NUM_CH];

    // Sum stage.
    logic                 sum_valid_reg;
    flags_t               sum_flags_reg;
    logic [PROD_BITS-1:0] sum_reg [NUM_CH];

    // Divider stages.
    logic                 dv_valid_reg [CH_BITS];
    flags_t               dv_flags_reg [CH_BITS];
    logic [PROD_BITS-1:0] dv_rem_reg   [CH_BITS][NUM_CH];
    logic [CH_BITS-1:0]   dv_quo_reg   [CH_BITS][NUM_CH];

    assign a_ch[0] = stop_lo.red;
    assign a_ch[1] = stop_lo.green;
    assign a_ch[2] = stop_lo.blue;
    assign b_ch[0] = stop_hi.red;
    assign b_ch[1] = stop_hi.green;
    assign b_ch[2] = stop_hi.blue;

    assign rest = divisor - step_k;

    // Control of the product and sum stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            sum_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_flags_reg <= in_flags;
        sum_flags_reg  <= prod_flags_reg;
    end

    // Weighted products and their sum, one channel per lane.
    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_lane
        logic [PROD_BITS-1:0] prod_a_next;
        logic [PROD_BITS-1:0] prod_b_next;

        assign prod_a_next = PROD_BITS'(a_ch[c]) * PROD_BITS'(rest);
        // With no step the upper stop carries no weight and is not looked at.
        assign prod_b_next = (step_k == '0) ? '0 : PROD_BITS'(b_ch[c]) * PROD_BITS'(step_k);

        always_ff @(posedge clk)
        begin
            prod_a_reg[c] <= prod_a_next;
            prod_b_reg[c] <= prod_b_next;
            sum_reg[c]    <= prod_a_reg[c] + prod_b_reg[c];
        end
    end

    // Restoring division by the segment length, most significant bit first.
    for (genvar j = 0; j < CH_BITS; j++)
    begin : g_div
        localparam int SHIFT = CH_BITS - 1 - j;

        logic                 prev_valid;
        flags_t               prev_flags;
        logic [PROD_BITS-1:0] shifted;

        assign shifted = PROD_BITS'(divisor) << SHIFT;

        if (j == 0)
        begin : g_first
            assign prev_valid = sum_valid_reg;
            assign prev_flags = sum_flags_reg;
        end
        else
        begin : g_chain
            assign prev_valid = dv_valid_reg[j-1];
            assign prev_flags = dv_flags_reg[j-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j] <= 1'b0;
            end
            else
            begin
                dv_valid_reg[j] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            dv_flags_reg[j] <= prev_flags;
        end

        for (genvar c = 0; c < NUM_CH; c++)
        begin : g_ch
            logic [PROD_BITS-1:0] prev_rem;
            logic [CH_BITS-1:0]   prev_quo;
            logic [PROD_BITS-1:0] rem_next;
            logic [CH_BITS-1:0]   quo_next;

            if (j == 0)
            begin : g_first
                assign prev_rem = sum_reg[c];
                assign prev_quo = '0;
            end
            else
            begin : g_chain
                assign prev_rem = dv_rem_reg[j-1][c];
                assign prev_quo = dv_quo_reg[j-1][c];
            end

            always_comb
            begin
                rem_next = prev_rem;
                quo_next = prev_quo;
                if (prev_rem >= shifted)
                begin
                    rem_next        = prev_rem - shifted;
                    quo_next[SHIFT] = 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                dv_rem_reg[j][c] <= rem_next;
                dv_quo_reg[j][c] <= quo_next;
            end
        end
    end

    assign out_valid    = dv_valid_reg[CH_BITS-1];
    assign out_flags    = dv_flags_reg[CH_BITS-1];
    assign colour.red   = dv_quo_reg[CH_BITS-1][0];
    assign colour.green = dv_quo_reg[CH_BITS-1][1];
    assign colour.blue  = dv_quo_reg[CH_BITS-1][2];

`ifndef NO_ASSERTIONS
    // Product, sum and one stage per result bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, CH_BITS + 2))
    else $error("crtl_blend: output beat without matching input beat");

    // A good division ends with every remainder below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_flags.error) |->
        (dv_rem_reg[CH_BITS-1][0] < PROD_BITS'(divisor)) &&
        (dv_rem_reg[CH_BITS-1][1] < PROD_BITS'(divisor)) &&
        (dv_rem_reg[CH_BITS-1][2] < PROD_BITS'(divisor)))
    else $error("crtl_blend: final remainder not below steps per segment");
`endif

endmodule

// ===== rtl/colour_ramp_texel_lookup.sv =====
// ============================================================================
// colour_ramp_texel_lookup
// Piecewise-linear RGB8 gradient built from a table of colour stops.
// ============================================================================
//
// Usage:
//   A beat on the command channel is taken at an edge where start is high
//   and busy is low. busy never rises, so a beat may be sent every cycle.
//   operation 0 loads one colour stop and gives no result; operation 1 looks
//   up one texel and gives exactly one result beat.
//   A result is on the result port for one cycle, marked by done, after its
//   start beat has passed one input stage, four segment divider stages, the
//   stop table read, a product and a sum stage, eight blend divider stages
//   and the output register. The two restoring divider chains, one bit per
//   stage, make up most of these stages. Throughput is one beat per cycle.
//   Loads write the table at the same stage where lookups read it, so every
//   beat sees exactly the loads sent before it.
//   Configuration (stop count, steps per segment) is written through the
//   cfg port while no lookup is in flight.
//   Reset sets 2 stops and 1 step per segment and empties the pipeline; the
//   stop table is undefined until loaded. The receiver cannot hold off a
//   result: it must take each done beat as it comes.
//
module colour_ramp_texel_lookup (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  crtl_pkg::item_t                    item,
    output logic                               done,
    output crtl_pkg::result_t                  result,
    input  logic                               cfg_write,
    input  crtl_pkg::cfg_reg_t                 cfg_index,
    input  logic [crtl_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import crtl_pkg::*;

    localparam int LATENCY = STOP_BITS + CH_BITS + 5;

    // Configuration.
    logic [COUNT_BITS-1:0] stop_count_reg;
    logic [COUNT_BITS-1:0] stop_count_next;
    logic [STEP_BITS-1:0]  steps_reg;
    logic [STEP_BITS-1:0]  steps_next;

    // Input stage.
    logic  in_valid_reg;
    item_t in_item_reg;

    // Classification of the registered beat.
    logic [N_BITS-1:0]   n_sat;
    logic [CMP_BITS-1:0] span;
    logic [CMP_BITS-1:0] t_ext;
    logic                empty;
    flags_t              cls_flags;
    load_t               cls_load;

    // Segment divider outputs.
    logic                 q_valid;
    flags_t               q_flags;
    load_t                q_load;
    logic [STOP_BITS-1:0] q_quot;
    logic [REM_BITS-1:0]  q_rem;

    // Table stage.
    logic [STOP_BITS-1:0] rd_addr_a;
    logic [STOP_BITS-1:0] rd_addr_b;
    logic [STEP_BITS-1:0] k_next;
    stop_t                stop_lo;
    stop_t                stop_hi;
    logic                 m_valid_reg;
    flags_t               m_flags_reg;
    logic [STEP_BITS-1:0] m_k_reg;

    // Blend outputs and output register.
    logic    bl_valid;
    flags_t  bl_flags;
    stop_t   bl_colour;
    logic    done_reg;
    logic    done_next;
    result_t result_reg;
    result_t result_next;

    // Every beat can be taken; the pipeline never stalls.
    assign busy = 1'b0;

    // Configuration writes.
    always_comb
    begin
        stop_count_next = stop_count_reg;
        steps_next      = steps_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_STOP_COUNT: stop_count_next = cfg_data[COUNT_BITS-1:0];
                CFG_STEPS:      steps_next      = cfg_data[STEP_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg <= COUNT_BITS'(2);
            steps_reg      <= STEP_BITS'(1);
        end
        else
        begin
            stop_count_reg <= stop_count_next;
            steps_reg      <= steps_next;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= item;
    end

    // The gradient has (N-1)*S+1 texels; the last sits at index (N-1)*S.
    assign n_sat = (N_BITS'(stop_count_reg) > N_BITS'(MAX_STOPS)) ?
                   N_BITS'(MAX_STOPS) : N_BITS'(stop_count_reg);
    assign span  = CMP_BITS'(n_sat - N_BITS'(1)) * CMP_BITS'(steps_reg);
    assign t_ext = CMP_BITS'(in_item_reg.texel_index);
    assign empty = (n_sat == '0) || (steps_reg == '0);

    always_comb
    begin
        cls_flags.lookup = in_item_reg.operation;
        cls_flags.error  = empty || (t_ext > span);
        cls_flags.last   = !empty && (t_ext == span);
        cls_load.en      = !in_item_reg.operation &&
                           (int'(in_item_reg.stop_index) < MAX_STOPS);
        cls_load.addr    = STOP_BITS'(in_item_reg.stop_index);
        cls_load.colour.red   = in_item_reg.stop_red;
        cls_load.colour.green = in_item_reg.stop_green;
        cls_load.colour.blue  = in_item_reg.stop_blue;
    end

    crtl_quot u_quot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_flags  (cls_flags),
        .in_load   (cls_load),
        .dividend  (REM_BITS'(in_item_reg.texel_index)),
        .divisor   (steps_reg),
        .out_valid (q_valid),
        .out_flags (q_flags),
        .out_load  (q_load),
        .quotient  (q_quot),
        .remainder (q_rem)
    );

    // The last texel reads stop N-1 with no step, which returns it exactly.
    assign rd_addr_a = q_flags.last ? STOP_BITS'(n_sat - N_BITS'(1)) : q_quot;
    assign rd_addr_b = rd_addr_a + STOP_BITS'(1);
    assign k_next    = q_flags.last ? '0 : q_rem[STEP_BITS-1:0];

    crtl_stop_ram u_ram (
        .clk       (clk),
        .wr_en     (q_valid && q_load.en),
        .wr_addr   (q_load.addr),
        .wr_data   (q_load.colour),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (stop_lo),
        .rd_data_b (stop_hi)
    );

    // Side information kept level with the table read; only lookups go on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= q_valid && q_flags.lookup;
        end
    end

    always_ff @(posedge clk)
    begin
        m_flags_reg <= q_flags;
        m_k_reg     <= k_next;
    end

    crtl_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m_valid_reg),
        .in_flags  (m_flags_reg),
        .step_k    (m_k_reg),
        .divisor   (steps_reg),
        .stop_lo   (stop_lo),
        .stop_hi   (stop_hi),
        .out_valid (bl_valid),
        .out_flags (bl_flags),
        .colour    (bl_colour)
    );

    // Output register; an index beyond the end or an empty gradient gives black and the error flag.
    always_comb
    begin
        done_next   = bl_valid;
        result_next = '0;
        if (bl_flags.error)
        begin
            result_next.index_error = 1'b1;
        end
        else
        begin
            result_next.texel_red   = bl_colour.red;
            result_next.texel_green = bl_colour.green;
            result_next.texel_blue  = bl_colour.blue;
            result_next.last_texel  = bl_flags.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    // Every result beat traces back to an earlier start beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
    else $error("colour_ramp_texel_lookup: result beat without a start beat");

    // A texel is never both the final one and out of range.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.last_texel && result.index_error))
    else $error("colour_ramp_texel_lookup: last texel flagged as index error");
`endif

endmodule
